// ===== rtl/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants of the power rail supervisor
// Field widths, register indexes, item codes, reset values and the
// configuration and result records passed between modules.
// ----------------------------------------------------------------------------
package prs_pkg;

    // Field widths
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned SHORT_W  = 15;
    localparam int unsigned FORCE_W  = 2;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Item kinds
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CMD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_ALL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SERVO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_IVL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IND_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ARMED_WAIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ARMED_BLINK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IND_ON       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IND_OFF      = 3'd7;

    // Configuration reset values
    localparam logic [SAMPLE_W-1:0] RST_CUTOFF_ALL   = 10'h283;
    localparam logic [SAMPLE_W-1:0] RST_CUTOFF_SERVO = 10'h298;
    localparam logic [TICK_W-1:0]   RST_CHECK_IVL    = 16'd50;
    localparam logic [TICK_W-1:0]   RST_IND_STEP     = 16'd40;
    localparam logic [SHORT_W-1:0]  RST_ARMED_WAIT   = 15'd100;
    localparam logic [SHORT_W-1:0]  RST_ARMED_BLINK  = 15'd50;
    localparam logic [TICK_W-1:0]   RST_IND_ON       = 16'd170;
    localparam logic [TICK_W-1:0]   RST_IND_OFF      = 16'd30;

    // Supervisor state reset values
    localparam logic [TICK_W-1:0]   INIT_BLINK      = 16'd110;
    localparam logic [SAMPLE_W-1:0] RST_SAMPLE      = 10'd1023;
    localparam logic [BYTE_W-1:0]   RST_REQUEST     = 8'd5;
    localparam logic [SLOT_W-1:0]   RST_SLOT        = 4'd15;

    // Request bit positions
    localparam int unsigned GUN_BIT = 3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] cutoff_all_level;
        logic [SAMPLE_W-1:0] cutoff_servo_level;
        logic [TICK_W-1:0]   check_interval;
        logic [TICK_W-1:0]   indicator_step;
        logic [SHORT_W-1:0]  armed_wait_time;
        logic [SHORT_W-1:0]  armed_blink_time;
        logic [TICK_W-1:0]   indicator_on_time;
        logic [TICK_W-1:0]   indicator_off_time;
    } cfg_t;

    typedef struct packed {
        logic                power_on;
        logic                servos_on;
        logic                fans_on;
        logic                guns_on;
        logic                armed_led;
        logic                indicator_led;
        logic [SAMPLE_W-1:0] reported_sample;
        logic [BYTE_W-1:0]   reported_request;
        logic [FORCE_W-1:0]  reported_forced;
    } res_t;

endpackage

// ===== rtl/prs_if.sv =====
// ----------------------------------------------------------------------------
// prs_if: channel interfaces of the power rail supervisor
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface prs_in_if
    import prs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [SAMPLE_W-1:0] sample;
    logic [BYTE_W-1:0]   command_byte;

    modport source (output valid, func, sample, command_byte, input ready);
    modport sink   (input valid, func, sample, command_byte, output ready);
endinterface

interface prs_out_if
    import prs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                power_on;
    logic                servos_on;
    logic                fans_on;
    logic                guns_on;
    logic                armed_led;
    logic                indicator_led;
    logic [SAMPLE_W-1:0] reported_sample;
    logic [BYTE_W-1:0]   reported_request;
    logic [FORCE_W-1:0]  reported_forced;

    modport source (
        output valid, power_on, servos_on, fans_on, guns_on, armed_led,
               indicator_led, reported_sample, reported_request, reported_forced,
        input  ready
    );
    modport sink (
        input  valid, power_on, servos_on, fans_on, guns_on, armed_led,
               indicator_led, reported_sample, reported_request, reported_forced,
        output ready
    );
endinterface

// ===== rtl/power_rail_supervisor_top.sv =====
// ----------------------------------------------------------------------------
// power_rail_supervisor_top: power rail supervisor
// Input register, supervisor evaluation and result register, with the
// configuration register file.
//
//   channel  | direction | handshake     | beat
//   ---------+-----------+---------------+--------------------------------
//   item     | in        | valid/ready   | func, sample, command_byte
//   result   | out       | valid/ready   | rail enables, lamps, status
//   cfg      | in        | cfg_we        | cfg_index, cfg_data
//
// One beat per cycle is accepted unless the result side stalls; each beat
// yields one result (input register, then result register).
// The supervisor state updates as the beat moves from the input register
// into the result register, so each beat sees the state left by the last.
// A stalled result holds both stages; the input register frees as soon as
// the result register can take its beat.
// Reset restores the configuration defaults and the supervisor state.
// ----------------------------------------------------------------------------
module power_rail_supervisor_top
    import prs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    prs_in_if.sink                item,
    prs_out_if.source             result
);

    cfg_t                cfg;
    res_t                res;
    res_t                res_reg;
    logic                in_vld_reg;
    logic                out_vld_reg;
    logic [FUNC_W-1:0]   func_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [BYTE_W-1:0]   cmd_reg;
    logic                adv;
    logic                take;

    // Advance when a held beat can move into the result register
    assign adv        = in_vld_reg && (!out_vld_reg || result.ready);
    assign item.ready = !in_vld_reg || adv;
    assign take       = item.valid && item.ready;

    prs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    prs_eval u_eval (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (adv),
        .func         (func_reg),
        .sample       (sample_reg),
        .command_byte (cmd_reg),
        .cfg          (cfg),
        .res          (res)
    );

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg   <= item.func;
            sample_reg <= item.sample;
            cmd_reg    <= item.command_byte;
        end
    end

    // Result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Capture the result beat
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res;
        end
    end

    assign result.valid            = out_vld_reg;
    assign result.power_on         = res_reg.power_on;
    assign result.servos_on        = res_reg.servos_on;
    assign result.fans_on          = res_reg.fans_on;
    assign result.guns_on          = res_reg.guns_on;
    assign result.armed_led        = res_reg.armed_led;
    assign result.indicator_led    = res_reg.indicator_led;
    assign result.reported_sample  = res_reg.reported_sample;
    assign result.reported_request = res_reg.reported_request;
    assign result.reported_forced  = res_reg.reported_forced;

    // A beat that advances always shows up as a result
    a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_vld_reg)
        else $error("advanced beat lost before result register");

    // A held input beat stays until it advances
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !adv) |=> (in_vld_reg && $stable(func_reg) && $stable(cmd_reg)))
        else $error("held input beat changed");

    // An empty result stage never blocks the input
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> item.ready)
        else $error("input stalled with empty result stage");

endmodule

// ===== rtl/prs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// prs_cfg_regs: configuration register file
// Eight write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module prs_cfg_regs
    import prs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Load the addressed register, truncated to its width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cutoff_all_level   <= RST_CUTOFF_ALL;
            cfg_reg.cutoff_servo_level <= RST_CUTOFF_SERVO;
            cfg_reg.check_interval     <= RST_CHECK_IVL;
            cfg_reg.indicator_step     <= RST_IND_STEP;
            cfg_reg.armed_wait_time    <= RST_ARMED_WAIT;
            cfg_reg.armed_blink_time   <= RST_ARMED_BLINK;
            cfg_reg.indicator_on_time  <= RST_IND_ON;
            cfg_reg.indicator_off_time <= RST_IND_OFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CUTOFF_ALL:   cfg_reg.cutoff_all_level   <= cfg_data[SAMPLE_W-1:0];
                CFG_CUTOFF_SERVO: cfg_reg.cutoff_servo_level <= cfg_data[SAMPLE_W-1:0];
                CFG_CHECK_IVL:    cfg_reg.check_interval     <= cfg_data[TICK_W-1:0];
                CFG_IND_STEP:     cfg_reg.indicator_step     <= cfg_data[TICK_W-1:0];
                CFG_ARMED_WAIT:   cfg_reg.armed_wait_time    <= cfg_data[SHORT_W-1:0];
                CFG_ARMED_BLINK:  cfg_reg.armed_blink_time   <= cfg_data[SHORT_W-1:0];
                CFG_IND_ON:       cfg_reg.indicator_on_time  <= cfg_data[TICK_W-1:0];
                CFG_IND_OFF:      cfg_reg.indicator_off_time <= cfg_data[TICK_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/prs_eval.sv =====
// ----------------------------------------------------------------------------
// prs_eval: supervisor state and per-item evaluation
// Holds the tick counter, deadlines, lamps and force-off latches, and
// computes the next state and the result record for one item.
// ----------------------------------------------------------------------------
module prs_eval
    import prs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [FUNC_W-1:0]   func,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [BYTE_W-1:0]   command_byte,
    input  cfg_t                cfg,
    output res_t                res
);

    logic [TICK_W-1:0]   tick_reg,    tick_next;
    logic [SAMPLE_W-1:0] latest_reg,  latest_next;
    logic [BYTE_W-1:0]   req_reg,     req_next;
    logic [FORCE_W-1:0]  forced_reg,  forced_next;
    logic [TICK_W-1:0]   ad_reg,      ad_next;
    logic [TICK_W-1:0]   awd_reg,     awd_next;
    logic [TICK_W-1:0]   tm_reg,      tm_next;
    logic [SLOT_W-1:0]   slot_reg,    slot_next;
    logic [TICK_W-1:0]   pm_reg,      pm_next;
    logic [TICK_W-1:0]   cm_reg,      cm_next;
    logic [SAMPLE_W-1:0] prev_reg,    prev_next;
    logic                armed_reg,   armed_next;
    logic                ind_reg,     ind_next;

    logic [TICK_W-1:0]   t;
    logic [TICK_W-1:0]   ad_diff;
    logic [TICK_W-1:0]   awd_diff;
    logic                ad_pass;
    logic                awd_pass;
    logic [TICK_W-1:0]   period;
    logic                tog_hit;
    logic                pat_hit;
    logic                chk_hit;
    logic [SLOT_W-1:0]   slot_inc;
    logic                pat_bit;
    logic [SAMPLE_W-1:0] use_sample;
    logic [BYTE_W-1:0]   rails;

    // Time and wrap-safe deadline tests
    assign t        = tick_reg + TICK_W'(1);
    assign ad_diff  = t - ad_reg;
    assign awd_diff = t - awd_reg;
    assign ad_pass  = (ad_diff != '0) && !ad_diff[TICK_W-1];
    assign awd_pass = (awd_diff != '0) && !awd_diff[TICK_W-1];

    // Indicator, pattern and voltage check triggers
    assign period   = ind_reg ? cfg.indicator_on_time : cfg.indicator_off_time;
    assign tog_hit  = (t - tm_reg) >= period;
    assign pat_hit  = (t - pm_reg) > cfg.indicator_step;
    assign chk_hit  = (t - cm_reg) >= cfg.check_interval;
    assign slot_inc = slot_reg + SLOT_W'(1);
    assign use_sample = (sample < prev_reg) ? prev_reg : sample;

    // Pick the serial pattern bit for the new slot
    always_comb
    begin
        case (slot_inc)
            4'd0:    pat_bit = 1'b0;
            4'd1:    pat_bit = req_reg[0];
            4'd2:    pat_bit = req_reg[1];
            4'd3:    pat_bit = req_reg[2];
            4'd4:    pat_bit = req_reg[3];
            4'd5:    pat_bit = req_reg[4];
            default: pat_bit = 1'b1;
        endcase
    end

    // Apply one item to the state
    always_comb
    begin
        tick_next   = tick_reg;
        latest_next = latest_reg;
        req_next    = req_reg;
        forced_next = forced_reg;
        ad_next     = ad_reg;
        awd_next    = awd_reg;
        tm_next     = tm_reg;
        slot_next   = slot_reg;
        pm_next     = pm_reg;
        cm_next     = cm_reg;
        prev_next   = prev_reg;
        armed_next  = armed_reg;
        ind_next    = ind_reg;
        if (go)
        begin
            unique case (func)
                FUNC_TICK:
                begin
                    tick_next   = t;
                    latest_next = sample;
                    // drop an expired blink
                    if ((ad_reg != '0) && ad_pass)
                    begin
                        ad_next    = '0;
                        armed_next = 1'b0;
                    end
                    // schedule waits and blinks while guns are requested
                    if (req_reg[GUN_BIT])
                    begin
                        if ((ad_next == '0) && (awd_reg == '0))
                        begin
                            awd_next = (t + {1'b0, cfg.armed_wait_time}) | TICK_W'(1);
                        end
                        else if ((awd_reg != '0) && awd_pass)
                        begin
                            awd_next   = '0;
                            ad_next    = (t + {1'b0, cfg.armed_blink_time}) | TICK_W'(1);
                            armed_next = 1'b1;
                        end
                    end
                    else
                    begin
                        awd_next = '0;
                    end
                    // free-running indicator toggle
                    if (tog_hit)
                    begin
                        ind_next = !ind_reg;
                        tm_next  = tm_reg + period;
                    end
                    // serial pattern overrides the toggle
                    if (pat_hit)
                    begin
                        slot_next = slot_inc;
                        ind_next  = pat_bit;
                        pm_next   = t;
                    end
                    // voltage check and force-off latching
                    if (chk_hit)
                    begin
                        prev_next = sample;
                        cm_next   = t;
                        if (use_sample < cfg.cutoff_all_level)
                        begin
                            forced_next = forced_reg | 2'b11;
                            armed_next  = 1'b1;
                            ind_next    = 1'b0;
                        end
                        else if (use_sample < cfg.cutoff_servo_level)
                        begin
                            forced_next = forced_reg | 2'b10;
                        end
                    end
                end
                FUNC_CMD:
                begin
                    req_next = command_byte;
                end
                default:
                begin
                    req_next = req_reg;
                end
            endcase
        end
    end

    // Hold the supervisor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg   <= '0;
            latest_reg <= RST_SAMPLE;
            req_reg    <= RST_REQUEST;
            forced_reg <= '0;
            ad_reg     <= INIT_BLINK | TICK_W'(1);
            awd_reg    <= '0;
            tm_reg     <= '0;
            slot_reg   <= RST_SLOT;
            pm_reg     <= '0;
            cm_reg     <= '0;
            prev_reg   <= '0;
            armed_reg  <= 1'b1;
            ind_reg    <= 1'b1;
        end
        else
        begin
            tick_reg   <= tick_next;
            latest_reg <= latest_next;
            req_reg    <= req_next;
            forced_reg <= forced_next;
            ad_reg     <= ad_next;
            awd_reg    <= awd_next;
            tm_reg     <= tm_next;
            slot_reg   <= slot_next;
            pm_reg     <= pm_next;
            cm_reg     <= cm_next;
            prev_reg   <= prev_next;
            armed_reg  <= armed_next;
            ind_reg    <= ind_next;
        end
    end

    // Build the result from the updated state
    assign rails = req_next & ~{{(BYTE_W-FORCE_W){1'b0}}, forced_next};

    assign res.power_on         = rails[0];
    assign res.servos_on        = rails[1];
    assign res.fans_on          = rails[2];
    assign res.guns_on          = rails[3];
    assign res.armed_led        = armed_next;
    assign res.indicator_led    = ind_next;
    assign res.reported_sample  = latest_next;
    assign res.reported_request = req_next;
    assign res.reported_forced  = forced_next;

    // Force-off latches never release
    a_forced_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (forced_reg[0] |=> forced_reg[0]) and (forced_reg[1] |=> forced_reg[1]))
        else $error("force-off latch released");

    // Power is never forced off without servos
    a_forced_order: assert property (@(posedge clk) disable iff (!rst_n)
        forced_reg[0] |-> forced_reg[1])
        else $error("power forced without servos");

    // At most one of the armed deadlines runs
    a_one_deadline: assert property (@(posedge clk) disable iff (!rst_n)
        !((ad_reg != '0) && (awd_reg != '0)))
        else $error("blink and wait deadlines both running");

    // A running deadline is odd so it never reads as idle
    a_deadline_odd: assert property (@(posedge clk) disable iff (!rst_n)
        ((ad_reg != '0) |-> ad_reg[0]) and ((awd_reg != '0) |-> awd_reg[0]))
        else $error("even armed deadline");

endmodule

// ===== bench/tb_power_rail_supervisor_top.sv =====
// ----------------------------------------------------------------------------
// tb_power_rail_supervisor_top: self-checking bench for the rail supervisor
// Drives tick, command and status beats through the item channel and checks
// every result beat against a cycle-free model of the supervisor kept in the
// bench. A short directed table comes first, then random phases under
// several register settings, including phases that latch the force-off
// bits. Both channels idle at random, and the result side holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module tb_power_rail_supervisor_top;
    import prs_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 64;
    localparam int REPORT_MAX   = 10;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [SAMPLE_W-1:0] sample;
        logic [BYTE_W-1:0]   command_byte;
        bit                  known;
        res_t                want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    prs_in_if  item_ch ();
    prs_out_if result_ch ();

    power_rail_supervisor_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    // Bench copy of the register file and the supervisor state
    cfg_t                sup_cfg;
    logic [TICK_W-1:0]   tick_now;
    logic [SAMPLE_W-1:0] last_sample;
    logic [BYTE_W-1:0]   req_byte;
    logic [FORCE_W-1:0]  forced_now;
    logic [TICK_W-1:0]   blink_end;
    logic [TICK_W-1:0]   wait_end;
    logic [TICK_W-1:0]   toggle_at;
    logic [SLOT_W-1:0]   slot;
    logic [TICK_W-1:0]   slot_at;
    logic [TICK_W-1:0]   check_at;
    logic [SAMPLE_W-1:0] prior_sample;
    logic                armed_lit;
    logic                ind_lit;
    int                  ticks_issued;

    res_t      predicted_beats[$];
    stim_row_t stim_rows[$];

    int fail_count;
    int beats_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_gen;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // True when t lies strictly after deadline d on the wrapping tick clock
    function automatic bit is_past(input logic [TICK_W-1:0] t, input logic [TICK_W-1:0] d);
        logic [TICK_W-1:0] diff;
        diff = t - d;
        return (diff != '0) && !diff[TICK_W-1];
    endfunction

    // Apply one item to the bench state and return the result beat it yields
    function automatic res_t supervise(input logic [FUNC_W-1:0] f,
                                       input logic [SAMPLE_W-1:0] s,
                                       input logic [BYTE_W-1:0] c);
        res_t                r;
        logic [BYTE_W-1:0]   rails;
        logic [TICK_W-1:0]   span;
        logic [TICK_W-1:0]   period;
        logic [SAMPLE_W-1:0] level;
        if (f == FUNC_TICK)
        begin
            tick_now = tick_now + 16'd1;
            ticks_issued++;
            last_sample = s;

            // drop the blink once its deadline has passed
            if (blink_end != '0 && is_past(tick_now, blink_end))
            begin
                blink_end = '0;
                armed_lit = 1'b0;
            end

            // schedule waits and blinks while guns are requested
            if (req_byte[GUN_BIT])
            begin
                if (blink_end == '0 && wait_end == '0)
                    wait_end = (tick_now + {1'b0, sup_cfg.armed_wait_time}) | 16'd1;
                else if (wait_end != '0 && is_past(tick_now, wait_end))
                begin
                    wait_end  = '0;
                    blink_end = (tick_now + {1'b0, sup_cfg.armed_blink_time}) | 16'd1;
                    armed_lit = 1'b1;
                end
            end
            else
                wait_end = '0;

            // free-running indicator toggle
            period = ind_lit ? sup_cfg.indicator_on_time : sup_cfg.indicator_off_time;
            span   = tick_now - toggle_at;
            if (span >= period)
            begin
                ind_lit   = ~ind_lit;
                toggle_at = toggle_at + period;
            end

            // advance the serial pattern and overwrite the lamp
            span = tick_now - slot_at;
            if (span > sup_cfg.indicator_step)
            begin
                slot = slot + 4'd1;
                if (slot == '0)
                    ind_lit = 1'b0;
                else if (slot <= 4'd5)
                    ind_lit = req_byte[slot - 4'd1];
                else
                    ind_lit = 1'b1;
                slot_at = tick_now;
            end

            // voltage check on the larger of this sample and the one kept at the last check
            span = tick_now - check_at;
            if (span >= sup_cfg.check_interval)
            begin
                level        = (last_sample < prior_sample) ? prior_sample : last_sample;
                prior_sample = last_sample;
                check_at     = tick_now;
                if (level < sup_cfg.cutoff_all_level)
                begin
                    forced_now = forced_now | 2'b11;
                    armed_lit  = 1'b1;
                    ind_lit    = 1'b0;
                end
                else if (level < sup_cfg.cutoff_servo_level)
                    forced_now = forced_now | 2'b10;
            end
        end
        else if (f == FUNC_CMD)
            req_byte = c;

        rails             = req_byte & ~{{(BYTE_W-FORCE_W){1'b0}}, forced_now};
        r.power_on        = rails[0];
        r.servos_on       = rails[1];
        r.fans_on         = rails[2];
        r.guns_on         = rails[3];
        r.armed_led       = armed_lit;
        r.indicator_led   = ind_lit;
        r.reported_sample = last_sample;
        r.reported_request = req_byte;
        r.reported_forced = forced_now;
        return r;
    endfunction

    // Present one beat, hold it until accepted, then log its prediction
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [SAMPLE_W-1:0] s,
                             input logic [BYTE_W-1:0] c, input bit known, input res_t want);
        res_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.func         <= f;
        item_ch.sample       <= s;
        item_ch.command_byte <= c;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predicted = supervise(f, s, c);
        predicted_beats.push_back(known ? want : predicted);
        @(negedge clk);
    endtask

    task automatic add_row(input logic [FUNC_W-1:0] f, input logic [SAMPLE_W-1:0] s,
                           input logic [BYTE_W-1:0] c, input bit known, input res_t want);
        stim_row_t row;
        row.func         = f;
        row.sample       = s;
        row.command_byte = c;
        row.known        = known;
        row.want         = want;
        stim_rows.push_back(row);
    endtask

    // Write one register; the caller lowers the enable after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_CUTOFF_ALL:   sup_cfg.cutoff_all_level   = data[SAMPLE_W-1:0];
            CFG_CUTOFF_SERVO: sup_cfg.cutoff_servo_level = data[SAMPLE_W-1:0];
            CFG_CHECK_IVL:    sup_cfg.check_interval     = data[TICK_W-1:0];
            CFG_IND_STEP:     sup_cfg.indicator_step     = data[TICK_W-1:0];
            CFG_ARMED_WAIT:   sup_cfg.armed_wait_time    = data[SHORT_W-1:0];
            CFG_ARMED_BLINK:  sup_cfg.armed_blink_time   = data[SHORT_W-1:0];
            CFG_IND_ON:       sup_cfg.indicator_on_time  = data[TICK_W-1:0];
            CFG_IND_OFF:      sup_cfg.indicator_off_time = data[TICK_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Drain, load a full register setting, then stream random beats
    task automatic run_phase(input cfg_t s, input int n_items, input int min_ticks,
                             input int tick_pct, input bit high_samples, input bit squeeze);
        int                  n;
        int                  r;
        logic [FUNC_W-1:0]   f;
        logic [SAMPLE_W-1:0] smp;
        while (predicted_beats.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
        write_reg(CFG_CUTOFF_ALL,   {6'd0, s.cutoff_all_level});
        write_reg(CFG_CUTOFF_SERVO, {6'd0, s.cutoff_servo_level});
        write_reg(CFG_CHECK_IVL,    s.check_interval);
        write_reg(CFG_IND_STEP,     s.indicator_step);
        write_reg(CFG_ARMED_WAIT,   {1'b0, s.armed_wait_time});
        write_reg(CFG_ARMED_BLINK,  {1'b0, s.armed_blink_time});
        write_reg(CFG_IND_ON,       s.indicator_on_time);
        write_reg(CFG_IND_OFF,      s.indicator_off_time);
        cfg_we <= 1'b0;
        if (squeeze)
            stall_gen++;
        n = 0;
        while (n < n_items || ticks_issued < min_ticks)
        begin
            r = $urandom_range(99);
            if (r < tick_pct)
                f = FUNC_TICK;
            else
            begin
                r = $urandom_range(99);
                if (r < 50)
                    f = FUNC_CMD;
                else if (r < 85)
                    f = FUNC_STATUS;
                else
                    f = FUNC_UNUSED;
            end
            if (high_samples && $urandom_range(3) != 0)
                smp = SAMPLE_W'($urandom_range(1023, 600));
            else
                smp = SAMPLE_W'($urandom_range(1023));
            send_item(f, smp, BYTE_W'($urandom_range(255)), 1'b0, '0);
            n++;
        end
        item_ch.valid <= 1'b0;
    endtask

    // Result side: random ready, with one long hold-off on request
    initial
    begin : result_side
        int hold_left;
        int stall_seen;
        hold_left       = 0;
        stall_seen      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_seen != stall_gen)
            begin
                stall_seen      = stall_gen;
                hold_left       = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result beat with the oldest prediction
    always @(posedge clk)
    begin : check_results
        res_t got;
        res_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.power_on         = result_ch.power_on;
            got.servos_on        = result_ch.servos_on;
            got.fans_on          = result_ch.fans_on;
            got.guns_on          = result_ch.guns_on;
            got.armed_led        = result_ch.armed_led;
            got.indicator_led    = result_ch.indicator_led;
            got.reported_sample  = result_ch.reported_sample;
            got.reported_request = result_ch.reported_request;
            got.reported_forced  = result_ch.reported_forced;
            beats_seen++;
            if (predicted_beats.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("result beat %0d arrived with nothing outstanding", beats_seen);
            end
            else
            begin
                want = predicted_beats.pop_front();
                if (got.power_on !== want.power_on || got.servos_on !== want.servos_on ||
                    got.fans_on !== want.fans_on || got.guns_on !== want.guns_on ||
                    got.armed_led !== want.armed_led ||
                    got.indicator_led !== want.indicator_led ||
                    got.reported_sample !== want.reported_sample ||
                    got.reported_request !== want.reported_request ||
                    got.reported_forced !== want.reported_forced)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display({"result beat %0d: expected rails %b%b%b%b armed %b ind %b ",
                                  "sample %0d req %h forced %b, got rails %b%b%b%b armed %b ",
                                  "ind %b sample %0d req %h forced %b"},
                                 beats_seen, want.power_on, want.servos_on, want.fans_on,
                                 want.guns_on, want.armed_led, want.indicator_led,
                                 want.reported_sample, want.reported_request,
                                 want.reported_forced, got.power_on, got.servos_on,
                                 got.fans_on, got.guns_on, got.armed_led, got.indicator_led,
                                 got.reported_sample, got.reported_request,
                                 got.reported_forced);
                end
            end
        end
    end

    initial
    begin : watchdog
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        cfg_t s;
        int   i;

        // reset values of the bench model
        sup_cfg.cutoff_all_level   = RST_CUTOFF_ALL;
        sup_cfg.cutoff_servo_level = RST_CUTOFF_SERVO;
        sup_cfg.check_interval     = RST_CHECK_IVL;
        sup_cfg.indicator_step     = RST_IND_STEP;
        sup_cfg.armed_wait_time    = RST_ARMED_WAIT;
        sup_cfg.armed_blink_time   = RST_ARMED_BLINK;
        sup_cfg.indicator_on_time  = RST_IND_ON;
        sup_cfg.indicator_off_time = RST_IND_OFF;
        tick_now     = '0;
        last_sample  = RST_SAMPLE;
        req_byte     = RST_REQUEST;
        forced_now   = '0;
        blink_end    = INIT_BLINK | 16'd1;
        wait_end     = '0;
        toggle_at    = '0;
        slot         = RST_SLOT;
        slot_at      = '0;
        check_at     = '0;
        prior_sample = '0;
        armed_lit    = 1'b1;
        ind_lit      = 1'b1;
        ticks_issued = 0;
        fail_count   = 0;
        beats_seen   = 0;
        stall_gen    = 0;

        // hold every input at a known value through reset
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        item_ch.valid        = 1'b0;
        item_ch.func         = '0;
        item_ch.sample       = '0;
        item_ch.command_byte = '0;
        send_idle_pct        = 23;
        recv_idle_pct        = 72;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed table; rail bits below read power, servos, fans, guns
        add_row(FUNC_STATUS, 10'h000, 8'h00, 1'b1,
                res_t'({4'b1010, 2'b11, 10'd1023, 8'h05, 2'b00}));
        add_row(FUNC_UNUSED, 10'h3FF, 8'hFF, 1'b1,
                res_t'({4'b1010, 2'b11, 10'd1023, 8'h05, 2'b00}));
        add_row(FUNC_CMD,    10'h000, 8'hFF, 1'b1,
                res_t'({4'b1111, 2'b11, 10'd1023, 8'hFF, 2'b00}));
        add_row(FUNC_TICK,   10'h000, 8'h00, 1'b1,
                res_t'({4'b1111, 2'b11, 10'd0, 8'hFF, 2'b00}));
        add_row(FUNC_TICK,   10'h3FF, 8'h00, 1'b1,
                res_t'({4'b1111, 2'b11, 10'd1023, 8'hFF, 2'b00}));
        add_row(FUNC_STATUS, 10'h155, 8'hAA, 1'b1,
                res_t'({4'b1111, 2'b11, 10'd1023, 8'hFF, 2'b00}));
        add_row(FUNC_CMD,    10'h2AA, 8'h00, 1'b1,
                res_t'({4'b0000, 2'b11, 10'd1023, 8'h00, 2'b00}));
        add_row(FUNC_TICK,   10'h155, 8'hFF, 1'b0, '0);
        add_row(FUNC_TICK,   10'h2AA, 8'h55, 1'b0, '0);
        add_row(FUNC_CMD,    10'h000, 8'h08, 1'b0, '0);
        add_row(FUNC_TICK,   10'h3FF, 8'h00, 1'b0, '0);
        add_row(FUNC_TICK,   10'h200, 8'h00, 1'b0, '0);
        add_row(FUNC_TICK,   10'h1FF, 8'h00, 1'b0, '0);
        add_row(FUNC_CMD,    10'h3FF, 8'hAA, 1'b0, '0);
        add_row(FUNC_TICK,   10'h000, 8'hFF, 1'b0, '0);
        add_row(FUNC_UNUSED, 10'h000, 8'h00, 1'b0, '0);
        add_row(FUNC_CMD,    10'h155, 8'h55, 1'b0, '0);
        add_row(FUNC_TICK,   10'h3FF, 8'h00, 1'b0, '0);
        add_row(FUNC_STATUS, 10'h3FF, 8'hFF, 1'b0, '0);
        add_row(FUNC_CMD,    10'h000, 8'h0F, 1'b0, '0);
        add_row(FUNC_TICK,   10'h100, 8'h00, 1'b0, '0);
        for (i = 0; i < stim_rows.size(); i++)
            send_item(stim_rows[i].func, stim_rows[i].sample, stim_rows[i].command_byte,
                      stim_rows[i].known, stim_rows[i].want);
        item_ch.valid <= 1'b0;

        // zero periods: the toggle, pattern and check tests fire on every tick
        s = '0;
        run_phase(s, 300, 0, 70, 1'b0, 1'b0);

        // widest periods, cutoffs kept at zero so nothing latches
        s.check_interval     = 16'hFFFF;
        s.indicator_step     = 16'hFFFF;
        s.armed_wait_time    = 15'h7FFF;
        s.armed_blink_time   = 15'h7FFF;
        s.indicator_on_time  = 16'hFFFF;
        s.indicator_off_time = 16'hFFFF;
        run_phase(s, 300, 0, 70, 1'b0, 1'b0);

        // short random periods; hold off the result side once
        send_idle_pct = 72;
        recv_idle_pct = 23;
        for (i = 0; i < 2; i++)
        begin
            s.check_interval     = TICK_W'($urandom_range(12, 1));
            s.indicator_step     = TICK_W'($urandom_range(20));
            s.armed_wait_time    = SHORT_W'($urandom_range(30));
            s.armed_blink_time   = SHORT_W'($urandom_range(30));
            s.indicator_on_time  = TICK_W'($urandom_range(25));
            s.indicator_off_time = TICK_W'($urandom_range(25));
            run_phase(s, 350, 0, 70, 1'b0, i == 0);
        end

        // mid-range periods with no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        s.check_interval     = TICK_W'($urandom_range(40, 1));
        s.indicator_step     = TICK_W'($urandom_range(60));
        s.armed_wait_time    = SHORT_W'($urandom_range(200));
        s.armed_blink_time   = SHORT_W'($urandom_range(200));
        s.indicator_on_time  = TICK_W'($urandom_range(100));
        s.indicator_off_time = TICK_W'($urandom_range(100));
        run_phase(s, 300, 0, 94, 1'b0, 1'b0);

        // servo cutoff only: servos latch off
        s.cutoff_servo_level = 10'd600;
        s.check_interval     = 16'd3;
        s.indicator_step     = TICK_W'($urandom_range(20));
        s.armed_wait_time    = SHORT_W'($urandom_range(30));
        s.armed_blink_time   = SHORT_W'($urandom_range(30));
        run_phase(s, 300, 0, 70, 1'b1, 1'b0);

        // top cutoffs: power and servos latch off
        s.cutoff_all_level   = 10'h3FF;
        s.cutoff_servo_level = 10'h3FF;
        s.check_interval     = TICK_W'($urandom_range(15, 5));
        run_phase(s, 300, 0, 70, 1'b0, 1'b0);

        // let the last results drain, then watch for strays
        while (predicted_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/prs_pkg.sv
rtl/prs_if.sv
rtl/prs_cfg_regs.sv
rtl/prs_eval.sv
rtl/power_rail_supervisor_top.sv
bench/tb_power_rail_supervisor_top.sv
